@@ rtl/lbfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfp_pkg
// Shared constants and control types for the LSB-first bit field packer.
// ----------------------------------------------------------------------------
package lbfp_pkg;

  localparam int BUF_BYTES = 256;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CUR_W     = ADDR_W + 1;
  localparam int OFF_W     = 3;
  localparam int LEN_W     = 6;
  localparam int DATA_W    = 32;
  localparam int MAX_FIELD = 32;
  localparam int NEED_W    = CUR_W + OFF_W + 1;

  localparam logic [1:0] REQ_WR_FIELD = 2'd0;
  localparam logic [1:0] REQ_WR_BIT   = 2'd1;
  localparam logic [1:0] REQ_RD_FIELD = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch the accepted beat
    logic step;      // process one byte chunk
    logic load_out;  // capture result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_work;     // accepted request touches the buffer
    logic last_chunk;  // current chunk finishes the field
  } status_t;

endpackage

@@ rtl/lbfp_ram.sv @@
// ----------------------------------------------------------------------------
// lbfp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lbfp_dp.sv @@
// ----------------------------------------------------------------------------
// lbfp_dp
// Datapath: cursors, shared bit offset, byte buffer and per-chunk merge logic.
// ----------------------------------------------------------------------------
module lbfp_dp import lbfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        in_req,
  input  logic [DATA_W-1:0] in_value,
  input  logic [LEN_W-1:0]  in_bits,
  input  cmd_t              cmd,
  output status_t           st,
  output logic [DATA_W-1:0] out_data,
  output logic              out_ovf,
  output logic [CUR_W-1:0]  out_wbytes,
  output logic [CUR_W-1:0]  out_rbytes
);

  logic [1:0]          req;
  logic [DATA_W-1:0]   value;
  logic [LEN_W-1:0]    rem;
  logic [LEN_W-1:0]    done;
  logic [DATA_W-1:0]   acc;
  logic                ovf;
  logic [CUR_W-1:0]    wcur;
  logic [CUR_W-1:0]    rcur;
  logic [OFF_W-1:0]    off;
  logic [BUF_BYTES-1:0] vld;
  logic                rvld;

  logic [LEN_W-1:0]  n_clamp;
  logic [LEN_W-1:0]  n_use;
  logic              active;
  logic [CUR_W-1:0]  cur_in;
  logic [NEED_W-1:0] need;
  logic              fits;

  logic [ADDR_W-1:0] cur;
  logic [3:0]        room;
  logic [3:0]        take;
  logic [3:0]        off_sum;
  logic [7:0]        mask;
  logic [7:0]        keep;
  logic [7:0]        bit_mask;
  logic [7:0]        rdata;
  logic [7:0]        old_byte;
  logic [7:0]        new_field;
  logic [7:0]        new_bit;
  logic [7:0]        wdata;
  logic              we;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rd_chunk;

  // ---- accept-time checks ----
  always_comb begin
    n_clamp = (in_bits > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : in_bits;
    n_use   = (in_req == REQ_WR_BIT) ? LEN_W'(1) : n_clamp;
    unique case (in_req)
      REQ_WR_FIELD: active = (n_clamp != '0);
      REQ_WR_BIT:   active = 1'b1;
      REQ_RD_FIELD: active = (n_clamp != '0);
      default:      active = 1'b0;
    endcase
    cur_in = (in_req == REQ_RD_FIELD) ? rcur : wcur;
    need   = {1'b0, cur_in, 3'b000} + NEED_W'(off) + NEED_W'(n_use);
    fits   = (need <= NEED_W'(BUF_BYTES * 8));
  end

  assign st.go_work = active & fits;

  // ---- chunk logic ----
  always_comb begin
    cur       = (req == REQ_RD_FIELD) ? rcur[ADDR_W-1:0] : wcur[ADDR_W-1:0];
    room      = 4'd8 - {1'b0, off};
    take      = (rem < LEN_W'(room)) ? rem[3:0] : room;
    off_sum   = {1'b0, off} + take;
    mask      = 8'((9'd1 << take) - 9'd1);
    keep      = 8'((9'd1 << off) - 9'd1);
    bit_mask  = 8'd1 << off;
    old_byte  = rvld ? rdata : 8'd0;
    new_field = (old_byte & keep) | ((value[7:0] & mask) << off);
    new_bit   = value[0] ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
    wdata     = (req == REQ_WR_BIT) ? new_bit : new_field;
    we        = cmd.step && (req != REQ_RD_FIELD);
    rd_chunk  = (old_byte >> off) & mask;
    // while stepping, prefetch the next byte
    raddr     = cur + ADDR_W'(cmd.step);
  end

  assign st.last_chunk = (rem == LEN_W'(take));

  lbfp_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(cur),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // bytes never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (we) begin
        vld[cur] <= 1'b1;
      end
      rvld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcur <= '0;
      rcur <= '0;
      off  <= '0;
    end else if (cmd.step) begin
      off <= off_sum[OFF_W-1:0];
      if (req == REQ_RD_FIELD) begin
        rcur <= rcur + CUR_W'(off_sum[3]);
      end else begin
        wcur <= wcur + CUR_W'(off_sum[3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req   <= in_req;
      value <= in_value;
      rem   <= n_use;
      done  <= '0;
      acc   <= '0;
      ovf   <= active & ~fits;
    end else if (cmd.step) begin
      value <= value >> take;
      rem   <= rem - LEN_W'(take);
      done  <= done + LEN_W'(take);
      if (req == REQ_RD_FIELD) begin
        acc <= acc | (DATA_W'(rd_chunk) << done[4:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data   <= acc;
      out_ovf    <= ovf;
      out_wbytes <= wcur;
      out_rbytes <= rcur;
    end
  end

endmodule

@@ rtl/lbfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbfp_ctrl
// Controller: sequences accept, byte fetch, chunk steps and result hand-off.
// ----------------------------------------------------------------------------
module lbfp_ctrl import lbfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_WORK,
    S_FINISH
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  // S_FETCH needs no command: the datapath addresses the byte under the cursor
  always_comb begin
    cmd.start    = (state == S_IDLE) && s_tvalid;
    cmd.step     = (state == S_WORK);
    cmd.load_out = (state == S_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= cmd.load_out | (m_tvalid & ~m_tready);
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= st.go_work ? S_FETCH : S_FINISH;
          end
        end
        S_FETCH: state <= S_WORK;
        S_WORK: begin
          if (st.last_chunk) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/lsb_first_bit_field_packer_unit.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_field_packer_unit
// Packs and unpacks variable-width fields LSB first in a 256-byte buffer.
//
// Channel  Dir  Beat contents
// s_*      in   tuser: req_type[1:0]; tdata: write_value, field_bits
// m_*      out  tdata: read_data, overflow, write_bytes, read_bytes
//
// One request at a time. A dropped or no-op request goes straight to the
// result; a buffer access fetches the cursor byte, then steps one chunk per
// touched byte (up to 5 for a 32-bit field), limited by the single RAM
// read-modify-write path. Reset is synchronous; buffer bytes read as zero
// until written. A stalled result stays in the output register and the
// next beat is accepted once the controller is back in idle.
// ----------------------------------------------------------------------------
module lsb_first_bit_field_packer_unit import lbfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // write_value[31:0], field_bits[37:32], zero pad
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // read_data[31:0], overflow[32], write_bytes[41:33],
                                 // read_bytes[50:42], zero pad
);

  cmd_t              cmd;
  status_t           st;
  logic [DATA_W-1:0] out_data;
  logic              out_ovf;
  logic [CUR_W-1:0]  out_wbytes;
  logic [CUR_W-1:0]  out_rbytes;

  lbfp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .st      (st),
    .cmd     (cmd)
  );

  lbfp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_req    (s_tuser),
    .in_value  (s_tdata[31:0]),
    .in_bits   (s_tdata[37:32]),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data),
    .out_ovf   (out_ovf),
    .out_wbytes(out_wbytes),
    .out_rbytes(out_rbytes)
  );

  assign m_tdata = {5'd0, out_rbytes, out_wbytes, out_ovf, out_data};

endmodule
